// ===== design/pid_aw_pkg.sv =====
// Package for the PID controller with back-calculation anti-windup.
// Sequencer states, accumulator opcodes, register map and reset values.
// No dependencies.
package pid_aw_pkg;

    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 34;
    localparam int ADDR_W = 5;
    localparam int APB_W  = 32;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_SUM,
        ST_MI,
        ST_MD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD
    } t_mac_op;

    typedef enum logic [2:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_GAIN_W   = 3'd3,
        REG_OUT_LOW  = 3'd4,
        REG_OUT_HIGH = 3'd5
    } t_reg_idx;

    typedef struct packed {
        t_sample gain_p;
        t_sample gain_i;
        t_sample gain_d;
        t_sample gain_w;
        t_sample out_low;
        t_sample out_high;
    } t_cfg;

    localparam t_sample GAIN_RST     = 16'sd1024;
    localparam t_sample OUT_LOW_RST  = 16'sh8000;
    localparam t_sample OUT_HIGH_RST = 16'sh7fff;

endpackage

// ===== design/pid_aw_if.sv =====
// Stream interfaces for the PID controller: sample input and drive output.
// Depends on pid_aw_pkg.
interface pid_aw_in_if;
    import pid_aw_pkg::*;
    logic    valid;
    logic    ready;
    t_sample target;
    t_sample measured;
    modport source (output valid, output target, output measured, input ready);
    modport sink   (input valid, input target, input measured, output ready);
endinterface

interface pid_aw_out_if;
    import pid_aw_pkg::*;
    logic    valid;
    logic    ready;
    t_sample drive;
    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// ===== design/pid_aw_regs.sv =====
// APB configuration registers of the PID controller (gains and output limits).
// Depends on pid_aw_pkg.
module pid_aw_regs
    import pid_aw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [2:0]        i_wr_idx,
    input  t_sample           i_wr_data,
    input  logic [2:0]        i_rd_idx,
    output logic [APB_W-1:0]  o_rd_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p   <= GAIN_RST;
            r_cfg.gain_i   <= GAIN_RST;
            r_cfg.gain_d   <= GAIN_RST;
            r_cfg.gain_w   <= GAIN_RST;
            r_cfg.out_low  <= OUT_LOW_RST;
            r_cfg.out_high <= OUT_HIGH_RST;
        end else if (i_wr_en) begin
            case (i_wr_idx)
                REG_GAIN_P:   r_cfg.gain_p   <= i_wr_data;
                REG_GAIN_I:   r_cfg.gain_i   <= i_wr_data;
                REG_GAIN_D:   r_cfg.gain_d   <= i_wr_data;
                REG_GAIN_W:   r_cfg.gain_w   <= i_wr_data;
                REG_OUT_LOW:  r_cfg.out_low  <= i_wr_data;
                REG_OUT_HIGH: r_cfg.out_high <= i_wr_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (i_rd_idx)
            REG_GAIN_P:   o_rd_data = APB_W'(r_cfg.gain_p);
            REG_GAIN_I:   o_rd_data = APB_W'(r_cfg.gain_i);
            REG_GAIN_D:   o_rd_data = APB_W'(r_cfg.gain_d);
            REG_GAIN_W:   o_rd_data = APB_W'(r_cfg.gain_w);
            REG_OUT_LOW:  o_rd_data = APB_W'(r_cfg.out_low);
            REG_OUT_HIGH: o_rd_data = APB_W'(r_cfg.out_high);
            default:      o_rd_data = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/pid_aw_mac.sv =====
// Shared 16x16 signed multiplier with accumulator register.
// Depends on pid_aw_pkg.
module pid_aw_mac
    import pid_aw_pkg::*;
(
    input  logic    i_clk,
    input  t_mac_op i_op,
    input  t_sample i_a,
    input  t_sample i_b,
    output t_acc    o_acc
);

    logic signed [PROD_W-1:0] prod;
    t_acc                     prod_ext;
    t_acc                     r_acc;

    assign prod     = i_a * i_b;
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    always_ff @(posedge i_clk) begin
        case (i_op)
            MAC_LOAD: r_acc <= prod_ext;
            MAC_ADD:  r_acc <= r_acc + prod_ext;
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

// ===== design/pid_aw_q10.sv =====
// Sequencer of the PID controller: state register, next-state logic and handshake strobes.
// The top level lives in pid_antiwindup_q10.sv.
// Depends on pid_aw_pkg.
module pid_aw_seq
    import pid_aw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_free,
    output logic    o_in_ready,
    output logic    o_out_load,
    output t_state  o_state
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_BACK;
            ST_BACK: n_state = ST_SUM;
            ST_SUM:  n_state = ST_MI;
            ST_MI:   n_state = ST_MD;
            ST_MD:   n_state = ST_OUT;
            ST_OUT:  if (i_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = i_rst_n;
            ST_OUT:  o_out_load = i_out_free;
            default: begin
                o_in_ready = 1'b0;
                o_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ===== design/pid_antiwindup_q10.sv =====
// PID controller with back-calculation anti-windup, Q10 gains, 16-bit samples.
// One target/measured beat in gives one drive beat out: the beat is accepted while the
// sequencer is idle, then five sequencer steps follow. The single shared 16x16
// multiply-accumulate unit forms the back-calculation term and then the three
// controller products in turn. The drive beat sits in an output register, so the next
// item is accepted while it waits; that item then stalls in its last step until the
// register is free. Input is taken only while the sequencer is idle and out of reset.
// Gains and output limits sit on an APB port (register i at byte address 4*i); the user
// must write them only while idle, which the block itself does not enforce.
// Depends on pid_aw_pkg, pid_aw_if, pid_aw_regs, pid_aw_mac, pid_aw_seq.
module pid_antiwindup_q10
    import pid_aw_pkg::*;
#(
    parameter int GAIN_SHIFT = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pid_aw_in_if.sink          i_in,
    pid_aw_out_if.source       o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    localparam t_acc DIV_BIAS = ACC_W'((64'd1 << GAIN_SHIFT) - 64'd1);

    t_cfg    cfg;
    t_state  state;
    t_mac_op mac_op;
    t_sample mac_a;
    t_sample mac_b;
    t_acc    acc;
    logic    in_ready;
    logic    out_load;
    logic    out_free;
    logic    wr_en;

    t_sample r_tgt;
    t_sample r_meas;
    t_sample r_err;
    t_sample r_diff;
    t_sample r_esum;
    t_sample r_last;
    t_sample r_wind;
    t_sample r_drive;
    logic    r_out_valid;

    t_sample back;
    t_sample esum_add;
    t_sample n_esum;
    t_sample n_err;
    t_sample n_diff;
    t_sample total;
    t_sample n_drive;
    t_sample n_wind;

    function automatic t_sample sat17(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1]) begin
            return v[DATA_W] ? OUT_LOW_RST : OUT_HIGH_RST;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic t_sample sat_acc(input t_acc v);
        if (v > t_acc'(OUT_HIGH_RST)) begin
            return OUT_HIGH_RST;
        end
        if (v < t_acc'(OUT_LOW_RST)) begin
            return OUT_LOW_RST;
        end
        return v[DATA_W-1:0];
    endfunction

    // truncating divide by 2^GAIN_SHIFT: bias negatives before the shift
    function automatic t_acc div_trunc(input t_acc v);
        t_acc biased;
        biased = v + (v[ACC_W-1] ? DIV_BIAS : '0);
        return biased >>> GAIN_SHIFT;
    endfunction

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    pid_aw_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_idx  (paddr[4:2]),
        .i_wr_data (pwdata[DATA_W-1:0]),
        .i_rd_idx  (paddr[4:2]),
        .o_rd_data (prdata),
        .o_cfg     (cfg)
    );

    pid_aw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_out_load (out_load),
        .o_state    (state)
    );

    pid_aw_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (acc)
    );

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.drive = r_drive;

    always_comb begin
        mac_op = MAC_HOLD;
        mac_a  = cfg.gain_w;
        mac_b  = r_wind;
        case (state)
            ST_BACK: begin
                mac_op = MAC_LOAD;
                mac_a  = cfg.gain_w;
                mac_b  = r_wind;
            end
            ST_SUM: begin
                mac_op = MAC_LOAD;
                mac_a  = cfg.gain_p;
                mac_b  = r_err;
            end
            ST_MI: begin
                mac_op = MAC_ADD;
                mac_a  = cfg.gain_i;
                mac_b  = r_esum;
            end
            ST_MD: begin
                mac_op = MAC_ADD;
                mac_a  = cfg.gain_d;
                mac_b  = r_diff;
            end
            default: mac_op = MAC_HOLD;
        endcase
    end

    always_comb begin
        n_err    = sat17({r_tgt[DATA_W-1], r_tgt} - {r_meas[DATA_W-1], r_meas});
        n_diff   = sat17({r_meas[DATA_W-1], r_meas} - {r_last[DATA_W-1], r_last});
        back     = sat_acc(div_trunc(acc));
        esum_add = sat17({r_err[DATA_W-1], r_err} + {r_esum[DATA_W-1], r_esum});
        n_esum   = sat17({esum_add[DATA_W-1], esum_add} - {back[DATA_W-1], back});
        total    = sat_acc(div_trunc(acc));
        // high limit is tested first, so with crossed limits a total above out_high gives out_high
        if (total > cfg.out_high) begin
            n_drive = cfg.out_high;
        end else if (total < cfg.out_low) begin
            n_drive = cfg.out_low;
        end else begin
            n_drive = total;
        end
        n_wind = sat17({total[DATA_W-1], total} - {n_drive[DATA_W-1], n_drive});
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_tgt  <= i_in.target;
            r_meas <= i_in.measured;
        end
        if (out_load) begin
            r_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esum      <= '0;
            r_last      <= '0;
            r_wind      <= '0;
            r_err       <= '0;
            r_diff      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (state == ST_BACK) begin
                r_err  <= n_err;
                r_diff <= n_diff;
                r_last <= r_meas;
            end
            if (state == ST_SUM) begin
                r_esum <= n_esum;
            end
            if (out_load) begin
                r_wind      <= n_wind;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
